/* rtl/core/stk_pkg.sv */
// shared types, codes and character helpers for the script tokenizer
package stk_pkg;

    localparam int unsigned MAX_RESULTS = 4;
    localparam int unsigned RES_IDX_W   = $clog2(MAX_RESULTS);
    localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // token kinds
    localparam logic [4:0] K_END     = 5'd0;
    localparam logic [4:0] K_NUMBER  = 5'd1;
    localparam logic [4:0] K_IDENT   = 5'd2;
    localparam logic [4:0] K_DEFINE  = 5'd3;
    localparam logic [4:0] K_INCLUDE = 5'd4;
    localparam logic [4:0] K_SETDIR  = 5'd5;
    localparam logic [4:0] K_UNDEF   = 5'd6;
    localparam logic [4:0] K_STRING  = 5'd7;
    localparam logic [4:0] K_HASH    = 5'd8;
    localparam logic [4:0] K_COLON   = 5'd9;
    localparam logic [4:0] K_SEMI    = 5'd10;
    localparam logic [4:0] K_EQUALS  = 5'd11;
    localparam logic [4:0] K_LBRACE  = 5'd12;
    localparam logic [4:0] K_RBRACE  = 5'd13;
    localparam logic [4:0] K_LPAREN  = 5'd14;
    localparam logic [4:0] K_RPAREN  = 5'd15;
    localparam logic [4:0] K_LBRACK  = 5'd16;
    localparam logic [4:0] K_RBRACK  = 5'd17;
    localparam logic [4:0] K_COMMA   = 5'd18;
    localparam logic [4:0] K_APOS    = 5'd19;
    localparam logic [4:0] K_SLASH   = 5'd20;
    localparam logic [4:0] K_UNKNOWN = 5'd21;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [15:0] LINE_FIRST = 16'd1;
    localparam logic [15:0] LINE_SAT   = 16'hFFFF;

    typedef enum logic [2:0] {
        CC_SPECIAL,
        CC_NUMBER,
        CC_LETTER,
        CC_QUOTE,
        CC_SYMBOL
    } cclass_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        token_first;
        logic        token_end;
        logic [4:0]  kind;
        logic [15:0] line;
        logic        stream_end;
    } result_t;

    // all results caused by one input byte
    typedef struct packed {
        result_t [MAX_RESULTS-1:0] res;
        logic [RES_CNT_W-1:0]      count;
    } bundle_t;

    function automatic cclass_t char_class(input logic [7:0] c);
        cclass_t cc;
        if (c inside {["0":"9"], "-", "."})
            cc = CC_NUMBER;
        else if (c inside {["A":"Z"], ["a":"z"], "_"})
            cc = CC_LETTER;
        else if (c == CH_QUOTE)
            cc = CC_QUOTE;
        else if (c inside {["!":"~"]})
            cc = CC_SYMBOL;
        else
            cc = CC_SPECIAL;
        return cc;
    endfunction

endpackage

/* rtl/core/stk_front.sv */
// front end: byte classification, lexer mode and result bundle build
module stk_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_byte,
    input  logic               is_last,
    input  logic               queue_full,
    output logic               push,
    output stk_pkg::bundle_t   bundle
);

    typedef enum logic [2:0] {
        M_IDLE,
        M_NUM,
        M_IDENT,
        M_STR,
        M_SLASH,
        M_LINE,
        M_BLOCK,
        M_STAR
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [3:0]  hits_reg, hits_next;
    logic [2:0]  pos_reg, pos_next;
    logic [15:0] line_reg, line_next;
    logic        in_fire;

    // keywords (bit0 define, bit1 include, bit2 setdir, bit3 undef) still matching
    function automatic logic [3:0] kw_keep(input logic [2:0] pos, input logic [7:0] c);
        logic [3:0] k;
        case (pos)
            3'd0:    k = {c == "u", c == "s", c == "i", c == "d"};
            3'd1:    k = {c == "n", c == "e", c == "n", c == "e"};
            3'd2:    k = {c == "d", c == "t", c == "c", c == "f"};
            3'd3:    k = {c == "e", c == "d", c == "l", c == "i"};
            3'd4:    k = {c == "f", c == "i", c == "u", c == "n"};
            3'd5:    k = {1'b0, c == "r", c == "d", c == "e"};
            3'd6:    k = {1'b0, 1'b0, c == "e", 1'b0};
            default: k = 4'b0000;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] ident_kind(input logic [3:0] hits, input logic [2:0] pos);
        logic [4:0] k;
        if (hits[0] && pos == 3'd6)
            k = stk_pkg::K_DEFINE;
        else if (hits[1] && pos == 3'd7)
            k = stk_pkg::K_INCLUDE;
        else if (hits[2] && pos == 3'd6)
            k = stk_pkg::K_SETDIR;
        else if (hits[3] && pos == 3'd5)
            k = stk_pkg::K_UNDEF;
        else
            k = stk_pkg::K_IDENT;
        return k;
    endfunction

    function automatic logic [4:0] symbol_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            "#":     k = stk_pkg::K_HASH;
            ":":     k = stk_pkg::K_COLON;
            ";":     k = stk_pkg::K_SEMI;
            "=":     k = stk_pkg::K_EQUALS;
            "{":     k = stk_pkg::K_LBRACE;
            "}":     k = stk_pkg::K_RBRACE;
            "(":     k = stk_pkg::K_LPAREN;
            ")":     k = stk_pkg::K_RPAREN;
            "[":     k = stk_pkg::K_LBRACK;
            "]":     k = stk_pkg::K_RBRACK;
            ",":     k = stk_pkg::K_COMMA;
            "'":     k = stk_pkg::K_APOS;
            "/":     k = stk_pkg::K_SLASH;
            default: k = stk_pkg::K_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic stk_pkg::result_t mk_res(
        input logic [7:0]  b,
        input logic        v,
        input logic        f,
        input logic        e,
        input logic [4:0]  k,
        input logic [15:0] ln,
        input logic        se
    );
        stk_pkg::result_t r;
        r.out_byte    = b;
        r.byte_valid  = v;
        r.token_first = f;
        r.token_end   = e;
        r.kind        = k;
        r.line        = ln;
        r.stream_end  = se;
        return r;
    endfunction

    assign in_ready = !queue_full;
    assign in_fire  = in_valid && in_ready;
    assign push     = in_fire && (bundle.count != '0);

    always_comb
    begin
        stk_pkg::cclass_t             cc;
        logic                         again;
        logic [stk_pkg::RES_CNT_W-1:0] n;
        logic [7:0]                   str_byte;

        cc        = stk_pkg::char_class(in_byte);
        again     = 1'b0;
        n         = '0;
        str_byte  = (in_byte == stk_pkg::CH_DEL) ? 8'h00 : in_byte;
        mode_next = mode_reg;
        hits_next = hits_reg;
        pos_next  = pos_reg;
        line_next = line_reg;
        bundle    = '0;

        // first pass in the current mode
        case (mode_reg)
            M_NUM:
            begin
                if (cc == stk_pkg::CC_NUMBER) begin
                    bundle.res[n[stk_pkg::RES_IDX_W-1:0]] = mk_res(in_byte, 1'b1,
                        pos_next == 3'd0, 1'b0, stk_pkg::K_END, line_reg, 1'b0);
                    n = n + 1'b1;
                    if (pos_next != 3'd7)
                        pos_next = pos_next + 3'd1;
                end else begin
                    bundle.res[n[stk_pkg::RES_IDX_W-1:0]] = mk_res(8'h00, 1'b0, 1'b0, 1'b1,
                        stk_pkg::K_NUMBER, line_reg, 1'b0);
                    n = n + 1'b1;
                    again = 1'b1;
                end
            end
            M_IDENT:
            begin
                if (cc == stk_pkg::CC_NUMBER || cc == stk_pkg::CC_LETTER) begin
                    hits_next = hits_next & kw_keep(pos_next, in_byte);
                    bundle.res[n[stk_pkg::RES_IDX_W-1:0]] = mk_res(in_byte, 1'b1,
                        pos_next == 3'd0, 1'b0, stk_pkg::K_END, line_reg, 1'b0);
                    n = n + 1'b1;
                    if (pos_next != 3'd7)
                        pos_next = pos_next + 3'd1;
                end else begin
                    bundle.res[n[stk_pkg::RES_IDX_W-1:0]] = mk_res(8'h00, 1'b0, 1'b0, 1'b1,
                        ident_kind(hits_reg, pos_reg), line_reg, 1'b0);
                    n = n + 1'b1;
                    again = 1'b1;
                end
            end
            M_STR:
            begin
                if (in_byte == stk_pkg::CH_QUOTE) begin
                    bundle.res[n[stk_pkg::RES_IDX_W-1:0]] = mk_res(8'h00, 1'b0,
                        pos_reg == 3'd0, 1'b1, stk_pkg::K_STRING, line_reg, 1'b0);
                    n = n + 1'b1;
                    mode_next = M_IDLE;
                end else begin
                    bundle.res[n[stk_pkg::RES_IDX_W-1:0]] = mk_res(str_byte, 1'b1,
                        pos_next == 3'd0, 1'b0, stk_pkg::K_END, line_reg, 1'b0);
                    n = n + 1'b1;
                    if (pos_next != 3'd7)
                        pos_next = pos_next + 3'd1;
                end
            end
            M_SLASH:
            begin
                if (in_byte == stk_pkg::CH_SLASH)
                    mode_next = M_LINE;
                else if (in_byte == stk_pkg::CH_STAR)
                    mode_next = M_BLOCK;
                else begin
                    bundle.res[n[stk_pkg::RES_IDX_W-1:0]] = mk_res(stk_pkg::CH_SLASH, 1'b1,
                        1'b1, 1'b1, stk_pkg::K_SLASH, line_reg, 1'b0);
                    n = n + 1'b1;
                    again = 1'b1;
                end
            end
            M_LINE:
            begin
                if (in_byte == stk_pkg::CH_NL) begin
                    if (line_next != stk_pkg::LINE_SAT)
                        line_next = line_next + 16'd1;
                    mode_next = M_IDLE;
                end
            end
            M_BLOCK:
            begin
                if (in_byte == stk_pkg::CH_STAR)
                    mode_next = M_STAR;
                else if (in_byte == stk_pkg::CH_NL && line_next != stk_pkg::LINE_SAT)
                    line_next = line_next + 16'd1;
            end
            M_STAR:
            begin
                if (in_byte == stk_pkg::CH_SLASH)
                    mode_next = M_IDLE;
                else if (in_byte != stk_pkg::CH_STAR) begin
                    mode_next = M_BLOCK;
                    if (in_byte == stk_pkg::CH_NL && line_next != stk_pkg::LINE_SAT)
                        line_next = line_next + 16'd1;
                end
            end
            default:
            begin
                mode_next = M_IDLE;
            end
        endcase

        // idle dispatch, also for a byte that closed a token
        if (mode_reg == M_IDLE || again) begin
            mode_next = M_IDLE;
            hits_next = 4'hF;
            pos_next  = 3'd0;
            case (cc)
                stk_pkg::CC_NUMBER:
                begin
                    mode_next = M_NUM;
                    bundle.res[n[stk_pkg::RES_IDX_W-1:0]] = mk_res(in_byte, 1'b1, 1'b1, 1'b0,
                        stk_pkg::K_END, line_reg, 1'b0);
                    n = n + 1'b1;
                    pos_next = 3'd1;
                end
                stk_pkg::CC_LETTER:
                begin
                    mode_next = M_IDENT;
                    hits_next = kw_keep(3'd0, in_byte);
                    bundle.res[n[stk_pkg::RES_IDX_W-1:0]] = mk_res(in_byte, 1'b1, 1'b1, 1'b0,
                        stk_pkg::K_END, line_reg, 1'b0);
                    n = n + 1'b1;
                    pos_next = 3'd1;
                end
                stk_pkg::CC_QUOTE:
                begin
                    mode_next = M_STR;
                end
                stk_pkg::CC_SYMBOL:
                begin
                    if (in_byte == stk_pkg::CH_SLASH)
                        mode_next = M_SLASH;
                    else begin
                        bundle.res[n[stk_pkg::RES_IDX_W-1:0]] = mk_res(in_byte, 1'b1, 1'b1,
                            1'b1, symbol_kind(in_byte), line_reg, 1'b0);
                        n = n + 1'b1;
                    end
                end
                default:
                begin
                    if (in_byte == stk_pkg::CH_NL && line_next != stk_pkg::LINE_SAT)
                        line_next = line_next + 16'd1;
                end
            endcase
        end

        // last byte: close what is pending, then the stream end marker
        if (is_last) begin
            case (mode_next)
                M_NUM:
                begin
                    bundle.res[n[stk_pkg::RES_IDX_W-1:0]] = mk_res(8'h00, 1'b0, 1'b0, 1'b1,
                        stk_pkg::K_NUMBER, line_next, 1'b0);
                    n = n + 1'b1;
                end
                M_IDENT:
                begin
                    bundle.res[n[stk_pkg::RES_IDX_W-1:0]] = mk_res(8'h00, 1'b0, 1'b0, 1'b1,
                        ident_kind(hits_next, pos_next), line_next, 1'b0);
                    n = n + 1'b1;
                end
                M_STR:
                begin
                    bundle.res[n[stk_pkg::RES_IDX_W-1:0]] = mk_res(8'h00, 1'b0,
                        pos_next == 3'd0, 1'b1, stk_pkg::K_STRING, line_next, 1'b0);
                    n = n + 1'b1;
                end
                M_SLASH:
                begin
                    bundle.res[n[stk_pkg::RES_IDX_W-1:0]] = mk_res(stk_pkg::CH_SLASH, 1'b1,
                        1'b1, 1'b1, stk_pkg::K_SLASH, line_next, 1'b0);
                    n = n + 1'b1;
                end
                default:
                begin
                end
            endcase
            bundle.res[n[stk_pkg::RES_IDX_W-1:0]] = mk_res(8'h00, 1'b0, 1'b0, 1'b0,
                stk_pkg::K_END, line_next, 1'b1);
            n = n + 1'b1;
            mode_next = M_IDLE;
            hits_next = 4'hF;
            pos_next  = 3'd0;
            line_next = stk_pkg::LINE_FIRST;
        end

        bundle.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= M_IDLE;
            hits_reg <= 4'hF;
            pos_reg  <= 3'd0;
            line_reg <= stk_pkg::LINE_FIRST;
        end else if (in_fire) begin
            mode_reg <= mode_next;
            hits_reg <= hits_next;
            pos_reg  <= pos_next;
            line_reg <= line_next;
        end
    end

    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_last) |=> (mode_reg == M_IDLE && line_reg == stk_pkg::LINE_FIRST))
        else $error("lexer state not back to reset after last byte");

    a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_last) |-> (push && bundle.res[bundle.count[stk_pkg::RES_IDX_W-1:0]
            - 1'b1].stream_end))
        else $error("last byte did not queue a stream end request");

endmodule

/* rtl/core/stk_queue.sv */
// short bundle queue between front end and back end
module stk_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  stk_pkg::bundle_t push_data,
    input  logic             pop,
    output stk_pkg::bundle_t head,
    output logic             empty,
    output logic             full
);

    stk_pkg::bundle_t             mem_reg [stk_pkg::QUEUE_DEPTH];
    logic [stk_pkg::QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [stk_pkg::QCNT_W-1:0]   count_reg, count_next;

    assign head  = mem_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == stk_pkg::QCNT_W'(stk_pkg::QUEUE_DEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue read while empty");

endmodule

/* rtl/core/stk_back.sv */
// back end: unpacks queued bundles into single results behind an output register
module stk_back (
    input  logic               clk,
    input  logic               rst_n,
    input  stk_pkg::bundle_t   head,
    input  logic               empty,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output stk_pkg::result_t   out_res
);

    logic [stk_pkg::RES_IDX_W-1:0] sub_reg, sub_next;
    logic                          out_valid_reg, out_valid_next;
    stk_pkg::result_t              out_res_reg;
    logic                          load;
    logic                          last_sub;

    assign load     = !empty && (!out_valid_reg || out_ready);
    assign last_sub = ({1'b0, sub_reg} + 1'b1) == head.count;
    assign pop      = load && last_sub;

    always_comb
    begin
        sub_next       = sub_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (load) begin
            out_valid_next = 1'b1;
            sub_next       = last_sub ? '0 : sub_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sub_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            sub_reg       <= sub_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_res_reg <= head.res[sub_reg];
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    a_sub_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ({1'b0, sub_reg} < head.count))
        else $error("result index beyond queued bundle");

endmodule

/* rtl/core/script_tokenizer_top.sv */
// script tokenizer top level: front end, bundle queue and back end
// path: a bundle is stored in the queue, then each result goes to the output register
// throughput: one byte per cycle in while in_ready is high; a byte makes 0 to 4 results
// the output drains one result a cycle while out_ready is high, so bytes with several
// results can fill the four-entry bundle queue and drop in_ready until it has room again
// reset: asynchronous, active low; lexer idle, line count 1, queue and output empty
module script_tokenizer_top (
    input  logic        clk,
    input  logic        rst_n,
    // byte request channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        is_last,
    // token result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        token_first,
    output logic        token_end,
    output logic [4:0]  kind,
    output logic [15:0] line,
    output logic        stream_end
);

    stk_pkg::bundle_t front_bundle;
    stk_pkg::bundle_t queue_head;
    stk_pkg::result_t out_res;
    logic             push;
    logic             pop;
    logic             queue_empty;
    logic             queue_full;

    // front end: classifies each byte and works out every result it causes in one step
    stk_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .is_last    (is_last),
        .queue_full (queue_full),
        .push       (push),
        .bundle     (front_bundle)
    );

    // bundles wait here so the front end keeps taking bytes while results drain
    stk_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_bundle),
        .pop       (pop),
        .head      (queue_head),
        .empty     (queue_empty),
        .full      (queue_full)
    );

    // back end: one result per cycle into the output register while the output is not held
    stk_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (queue_head),
        .empty     (queue_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign out_byte    = out_res.out_byte;
    assign byte_valid  = out_res.byte_valid;
    assign token_first = out_res.token_first;
    assign token_end   = out_res.token_end;
    assign kind        = out_res.kind;
    assign line        = out_res.line;
    assign stream_end  = out_res.stream_end;

endmodule

/* tb/sv/tb.sv */
// self-checking testbench for script_tokenizer_top: directed table, random scripts, line flood
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stk_pkg::*;

    // lexer modes of the behavioural predictor
    typedef enum logic [2:0] {
        LX_IDLE,
        LX_NUM,
        LX_IDENT,
        LX_STR,
        LX_SLASH,
        LX_LINE,
        LX_BLOCK,
        LX_STAR
    } lex_mode_t;

    // one row of the directed table; want is only used where fixed is set
    typedef struct {
        logic [7:0] b;
        logic       fin;
        logic       fixed;
        result_t    want;
    } drill_row_t;

    localparam int IDLE_PCT    = 31;
    localparam int RANDOM_BYTES = 290;
    localparam int FLOOD_LINES  = 30;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_byte;
    logic        is_last;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        token_first;
    logic        token_end;
    logic [4:0]  kind;
    logic [15:0] line;
    logic        stream_end;

    // typed-in expectation travelling alongside the byte request
    logic        req_fixed;
    result_t     req_want;

    // predictor state
    lex_mode_t   lx_mode;
    logic [3:0]  kw_live;
    logic [2:0]  tok_pos;
    logic [15:0] line_no;
    string       kw_word [4];

    result_t     step_res [$];
    result_t     token_due [$];
    logic [7:0]  script_q [$];
    drill_row_t  drill [$];

    int          tx_idle;
    int          rx_idle;
    int          mismatches;
    int          random_fed;

    script_tokenizer_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .is_last     (is_last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .token_first (token_first),
        .token_end   (token_end),
        .kind        (kind),
        .line        (line),
        .stream_end  (stream_end)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // generous ceiling, several times the slowest legal run
    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    function automatic result_t mk_res(input logic [7:0] b, input logic v, input logic f,
                                       input logic e, input logic [4:0] k,
                                       input logic [15:0] ln, input logic se);
        result_t r;
        r.out_byte    = b;
        r.byte_valid  = v;
        r.token_first = f;
        r.token_end   = e;
        r.kind        = k;
        r.line        = ln;
        r.stream_end  = se;
        return r;
    endfunction

    function automatic void lex_reset();
        lx_mode = LX_IDLE;
        kw_live = 4'hF;
        tok_pos = 3'd0;
        line_no = LINE_FIRST;
    endfunction

    // at most four results can come from one byte
    function automatic void note(input logic [7:0] b, input logic v, input logic f,
                                 input logic e, input logic [4:0] k, input logic se);
        if (step_res.size() < MAX_RESULTS)
            step_res.push_back(mk_res(b, v, f, e, k, line_no, se));
    endfunction

    function automatic void bump_line(input logic [7:0] c);
        if (c == CH_NL && line_no != LINE_SAT)
            line_no = line_no + 16'd1;
    endfunction

    function automatic void tok_char(input logic [7:0] c);
        note(c, 1'b1, tok_pos == 3'd0, 1'b0, K_END, 1'b0);
        if (tok_pos != 3'd7)
            tok_pos = tok_pos + 3'd1;
    endfunction

    // knock out every keyword that no longer matches at this position
    function automatic void ident_char(input logic [7:0] c);
        for (int k = 0; k < 4; k++)
        begin
            if (tok_pos >= kw_word[k].len() || kw_word[k][tok_pos] != c)
                kw_live[k] = 1'b0;
        end
        tok_char(c);
    endfunction

    function automatic logic [4:0] ident_sort();
        for (int k = 0; k < 4; k++)
        begin
            if (kw_live[k] && tok_pos == kw_word[k].len())
                return K_DEFINE + 5'(k);
        end
        return K_IDENT;
    endfunction

    function automatic logic [4:0] symbol_sort(input logic [7:0] c);
        case (c)
            "#":     return K_HASH;
            ":":     return K_COLON;
            ";":     return K_SEMI;
            "=":     return K_EQUALS;
            "{":     return K_LBRACE;
            "}":     return K_RBRACE;
            "(":     return K_LPAREN;
            ")":     return K_RPAREN;
            "[":     return K_LBRACK;
            "]":     return K_RBRACK;
            ",":     return K_COMMA;
            "'":     return K_APOS;
            "/":     return K_SLASH;
            default: return K_UNKNOWN;
        endcase
    endfunction

    function automatic cclass_t classify(input logic [7:0] c);
        if ((c >= "0" && c <= "9") || c == "-" || c == ".")
            return CC_NUMBER;
        if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_")
            return CC_LETTER;
        if (c == CH_QUOTE)
            return CC_QUOTE;
        if (c >= "!" && c <= "~")
            return CC_SYMBOL;
        return CC_SPECIAL;
    endfunction

    function automatic void lex_byte(input logic [7:0] c);
        logic    again;
        cclass_t cls;
        again = 1'b1;
        while (again)
        begin
            cls   = classify(c);
            again = 1'b0;
            case (lx_mode)
                LX_NUM:
                    if (cls == CC_NUMBER)
                        tok_char(c);
                    else
                    begin
                        note(8'd0, 1'b0, 1'b0, 1'b1, K_NUMBER, 1'b0);
                        lx_mode = LX_IDLE;
                        again   = 1'b1;
                    end
                LX_IDENT:
                    if (cls == CC_LETTER || cls == CC_NUMBER)
                        ident_char(c);
                    else
                    begin
                        note(8'd0, 1'b0, 1'b0, 1'b1, ident_sort(), 1'b0);
                        lx_mode = LX_IDLE;
                        again   = 1'b1;
                    end
                LX_STR:
                    if (c == CH_QUOTE)
                    begin
                        note(8'd0, 1'b0, tok_pos == 3'd0, 1'b1, K_STRING, 1'b0);
                        lx_mode = LX_IDLE;
                    end
                    else
                        tok_char((c == CH_DEL) ? 8'd0 : c);
                LX_SLASH:
                    if (c == CH_SLASH)
                        lx_mode = LX_LINE;
                    else if (c == CH_STAR)
                        lx_mode = LX_BLOCK;
                    else
                    begin
                        note(CH_SLASH, 1'b1, 1'b1, 1'b1, K_SLASH, 1'b0);
                        lx_mode = LX_IDLE;
                        again   = 1'b1;
                    end
                LX_LINE:
                    if (c == CH_NL)
                    begin
                        bump_line(c);
                        lx_mode = LX_IDLE;
                    end
                LX_BLOCK:
                    if (c == CH_STAR)
                        lx_mode = LX_STAR;
                    else
                        bump_line(c);
                LX_STAR:
                    if (c == CH_SLASH)
                        lx_mode = LX_IDLE;
                    else if (c != CH_STAR)
                    begin
                        lx_mode = LX_BLOCK;
                        bump_line(c);
                    end
                default:
                begin
                    kw_live = 4'hF;
                    tok_pos = 3'd0;
                    if (cls == CC_NUMBER)
                    begin
                        lx_mode = LX_NUM;
                        tok_char(c);
                    end
                    else if (cls == CC_LETTER)
                    begin
                        lx_mode = LX_IDENT;
                        ident_char(c);
                    end
                    else if (cls == CC_QUOTE)
                        lx_mode = LX_STR;
                    else if (cls == CC_SYMBOL)
                    begin
                        if (c == CH_SLASH)
                            lx_mode = LX_SLASH;
                        else
                            note(c, 1'b1, 1'b1, 1'b1, symbol_sort(c), 1'b0);
                    end
                    else
                        bump_line(c);
                end
            endcase
        end
    endfunction

    // expected results of one accepted byte land in step_res
    function automatic void lex_step(input logic [7:0] c, input logic fin);
        step_res.delete();
        lex_byte(c);
        if (fin)
        begin
            case (lx_mode)
                LX_NUM:   note(8'd0, 1'b0, 1'b0, 1'b1, K_NUMBER, 1'b0);
                LX_IDENT: note(8'd0, 1'b0, 1'b0, 1'b1, ident_sort(), 1'b0);
                LX_STR:   note(8'd0, 1'b0, tok_pos == 3'd0, 1'b1, K_STRING, 1'b0);
                LX_SLASH: note(CH_SLASH, 1'b1, 1'b1, 1'b1, K_SLASH, 1'b0);
                default:  ;
            endcase
            note(8'd0, 1'b0, 1'b0, 1'b0, K_END, 1'b1);
            lex_reset();
        end
    endfunction

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------

    function automatic void cmp_field(input string what, input logic [15:0] want,
                                      input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // byte requests feed the predictor, token results are popped and compared;
    // requests are handled first so that same-edge ordering never matters
    always @(posedge clk)
    begin : watch
        result_t seen;
        result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                lex_step(in_byte, is_last);
                if (req_fixed)
                    token_due.push_back(req_want);
                else
                    foreach (step_res[i])
                        token_due.push_back(step_res[i]);
            end
            if (out_valid && out_ready)
            begin
                seen = {out_byte, byte_valid, token_first, token_end, kind, line, stream_end};
                if (token_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %h", $time, seen);
                    mismatches++;
                end
                else
                begin
                    want = token_due.pop_front();
                    cmp_field("out_byte", 16'(want.out_byte), 16'(seen.out_byte));
                    cmp_field("byte_valid", 16'(want.byte_valid), 16'(seen.byte_valid));
                    cmp_field("token_first", 16'(want.token_first), 16'(seen.token_first));
                    cmp_field("token_end", 16'(want.token_end), 16'(seen.token_end));
                    cmp_field("kind", 16'(want.kind), 16'(seen.kind));
                    cmp_field("line", want.line, seen.line);
                    cmp_field("stream_end", 16'(want.stream_end), 16'(seen.stream_end));
                end
            end
        end
    end

    // result side back-pressure, changed at the falling edge
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= rx_idle);

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    function automatic void add_row(input logic [7:0] b, input logic fin, input logic fx,
                                    input result_t w);
        drill_row_t r;
        r.b     = b;
        r.fin   = fin;
        r.fixed = fx;
        r.want  = w;
        drill.push_back(r);
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    // with valid still high, so the next request can follow back to back
    task automatic send_byte(input logic [7:0] b, input logic fin, input logic fx,
                             input result_t w);
        while ($urandom_range(99) < tx_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        in_byte   <= b;
        is_last   <= fin;
        req_fixed <= fx;
        req_want  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // the last byte of a script carries is_last
    task automatic send_script();
        for (int i = 0; i < script_q.size(); i++)
            send_byte(script_q[i], i == script_q.size() - 1, 1'b0, '0);
        script_q.delete();
    endtask

    // sender holds off until every outstanding result has been taken
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (token_due.size() != 0)
            @(negedge clk);
    endtask

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            script_q.push_back(s[i]);
    endfunction

    function automatic logic [7:0] word_char(input bit lead);
        case ($urandom_range(lead ? 2 : 5))
            0:       return 8'("A" + $urandom_range(25));
            1:       return 8'("a" + $urandom_range(25));
            2:       return "_";
            3:       return 8'("0" + $urandom_range(9));
            4:       return "-";
            default: return ".";
        endcase
    endfunction

    function automatic logic [7:0] num_char();
        case ($urandom_range(11))
            10:      return "-";
            11:      return ".";
            default: return 8'("0" + $urandom_range(9));
        endcase
    endfunction

    function automatic logic [7:0] string_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (c == CH_QUOTE);
        return c;
    endfunction

    // mostly well-formed tokens with random content, some noise
    function automatic void gen_token();
        string       w;
        string       syms;
        string       blk;
        int          n;
        syms = "#:;={}()[],'/";
        blk  = "*\n/a ";
        case ($urandom_range(15))
            0, 1:
            begin
                n = $urandom_range(1, 6);
                repeat (n) script_q.push_back(num_char());
            end
            2, 3, 4:
            begin
                script_q.push_back(word_char(1'b1));
                n = $urandom_range(0, 9);
                repeat (n) script_q.push_back(word_char(1'b0));
            end
            5, 6:
            begin
                // keywords and near misses
                w = kw_word[$urandom_range(3)];
                case ($urandom_range(3))
                    0: put_text(w);
                    1: put_text(w.substr(0, w.len() - 2));
                    2:
                    begin
                        put_text(w);
                        script_q.push_back(word_char(1'b0));
                    end
                    default:
                    begin
                        put_text(w.substr(0, w.len() - 2));
                        script_q.push_back("x");
                    end
                endcase
            end
            7, 8:
            begin
                script_q.push_back(CH_QUOTE);
                n = $urandom_range(0, 6);
                repeat (n) script_q.push_back(string_char());
                script_q.push_back(CH_QUOTE);
            end
            9:
            begin
                // quote left open, swallows what follows
                script_q.push_back(CH_QUOTE);
                n = $urandom_range(0, 3);
                repeat (n) script_q.push_back(string_char());
            end
            10, 11:
                script_q.push_back(syms[$urandom_range(12)]);
            12:
                script_q.push_back(8'($urandom_range(33, 126)));
            13:
            begin
                put_text("//");
                n = $urandom_range(0, 5);
                repeat (n) script_q.push_back(8'($urandom_range(32, 126)));
                script_q.push_back(CH_NL);
            end
            14:
            begin
                put_text("/*");
                n = $urandom_range(0, 6);
                repeat (n) script_q.push_back(blk[$urandom_range(4)]);
                put_text("*/");
            end
            default:
                script_q.push_back(8'($urandom_range(255)));
        endcase
    endfunction

    function automatic void gen_gap();
        case ($urandom_range(7))
            0:       ;
            1, 7:    script_q.push_back(" ");
            2:       script_q.push_back(CH_NL);
            3:       script_q.push_back("\t");
            4:       script_q.push_back(8'($urandom_range(31)));
            5:       script_q.push_back(CH_DEL);
            default: script_q.push_back(8'($urandom_range(128, 255)));
        endcase
    endfunction

    task automatic random_script(input int tokens);
        repeat (tokens)
        begin
            gen_token();
            gen_gap();
        end
        random_fed += script_q.size();
        send_script();
    endtask

    initial
    begin
        in_valid   = 1'b0;
        in_byte    = 8'd0;
        is_last    = 1'b0;
        out_ready  = 1'b0;
        req_fixed  = 1'b0;
        req_want   = '0;
        tx_idle    = IDLE_PCT;
        rx_idle    = IDLE_PCT;
        mismatches = 0;
        random_fed = 0;
        kw_word    = '{"define", "include", "setdir", "undef"};
        lex_reset();

        // directed table: fixed rows carry their result, the rest use the predictor
        add_row("#",      1'b0, 1'b1,
                mk_res("#", 1'b1, 1'b1, 1'b1, K_HASH, LINE_FIRST, 1'b0));
        add_row(8'h00,    1'b0, 1'b0, '0);
        add_row(8'hFF,    1'b0, 1'b0, '0);
        add_row("~",      1'b0, 1'b1,
                mk_res("~", 1'b1, 1'b1, 1'b1, K_UNKNOWN, LINE_FIRST, 1'b0));
        // keyword closed by a symbol
        add_row("d",      1'b0, 1'b0, '0);
        add_row("e",      1'b0, 1'b0, '0);
        add_row("f",      1'b0, 1'b0, '0);
        add_row("i",      1'b0, 1'b0, '0);
        add_row("n",      1'b0, 1'b0, '0);
        add_row("e",      1'b0, 1'b0, '0);
        add_row(";",      1'b0, 1'b0, '0);
        // string with a high byte, a DEL (sent on as a zero byte) and a newline kept as data
        add_row(CH_QUOTE, 1'b0, 1'b0, '0);
        add_row(8'hFF,    1'b0, 1'b0, '0);
        add_row(CH_DEL,   1'b0, 1'b0, '0);
        add_row(CH_NL,    1'b0, 1'b0, '0);
        add_row(CH_QUOTE, 1'b0, 1'b0, '0);
        // line comment, its newline still counts
        add_row(CH_SLASH, 1'b0, 1'b0, '0);
        add_row(CH_SLASH, 1'b0, 1'b0, '0);
        add_row("x",      1'b0, 1'b0, '0);
        add_row(CH_NL,    1'b0, 1'b0, '0);
        // block comment closed straight after a star
        add_row(CH_SLASH, 1'b0, 1'b0, '0);
        add_row(CH_STAR,  1'b0, 1'b0, '0);
        add_row(CH_STAR,  1'b0, 1'b0, '0);
        add_row(CH_SLASH, 1'b0, 1'b0, '0);
        // number ended by a slash, slash flushed by a quote, empty open string at the end
        add_row("-",      1'b0, 1'b0, '0);
        add_row(".",      1'b0, 1'b0, '0);
        add_row(CH_SLASH, 1'b0, 1'b0, '0);
        add_row(CH_QUOTE, 1'b1, 1'b0, '0);
        // lone separator as the last byte, state back at reset
        add_row(" ",      1'b1, 1'b1,
                mk_res(8'd0, 1'b0, 1'b0, 1'b0, K_END, LINE_FIRST, 1'b1));

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (drill[i])
            send_byte(drill[i].b, drill[i].fin, drill[i].fixed, drill[i].want);
        drain();

        // long stretch with no idling on either side
        tx_idle = 0;
        rx_idle = 0;
        random_script(40);
        tx_idle = IDLE_PCT;
        rx_idle = IDLE_PCT;

        while (random_fed < RANDOM_BYTES)
        begin
            random_script($urandom_range(1, 12));
            if ($urandom_range(3) == 0)
                drain();
        end

        // run of newlines, partly inside a block comment
        repeat (FLOOD_LINES) script_q.push_back(CH_NL);
        put_text("/*\n\n\n*/x\n7");
        send_script();

        drain();
        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
